[hw/rtl/lsd_pkg.sv]
`default_nettype none

package lsd_pkg;

  localparam int unsigned KS_BITS = 8;

  localparam logic [7:0] QUESTION_MARK = 8'd63;

  localparam logic [2:0] REG_TAP_MASK      = 3'd0;
  localparam logic [2:0] REG_INITIAL_STATE = 3'd1;
  localparam logic [2:0] REG_RIGHT_SHIFT   = 3'd2;
  localparam logic [2:0] REG_HIGH_FIRST    = 3'd3;
  localparam logic [2:0] REG_ALLOWED_0     = 3'd4;
  localparam logic [2:0] REG_ALLOWED_1     = 3'd5;
  localparam logic [2:0] REG_ALLOWED_2     = 3'd6;
  localparam logic [2:0] REG_ALLOWED_3     = 3'd7;

  localparam logic [7:0]  RST_TAP_MASK      = 8'd29;
  localparam logic [7:0]  RST_INITIAL_STATE = 8'd1;
  // space
  localparam logic [63:0] RST_ALLOWED_0     = 64'h0000_0001_0000_0000;
  // 'A' to 'Z'
  localparam logic [63:0] RST_ALLOWED_1     = 64'h0000_0000_07FF_FFFE;
  localparam logic [63:0] RST_ALLOWED_2     = 64'h0;
  localparam logic [63:0] RST_ALLOWED_3     = 64'h0;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       char_allowed;
    logic       last_out;
  } result_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] state_next;
  } keystream_t;

  // eight LFSR shifts, unrolled
  function automatic keystream_t keystream(input logic [7:0] state,
                                           input logic [7:0] taps,
                                           input logic       go_right,
                                           input logic       high_first);
    keystream_t res;
    logic [7:0] s;
    logic [7:0] acc;
    logic       fb;
    logic       bit_out;
    s   = state;
    acc = 8'd0;
    for (int i = 0; i < int'(KS_BITS); i++) begin
      fb = ^(s & taps);
      if (go_right) begin
        bit_out = s[0];
        s       = {fb, s[7:1]};
      end else begin
        bit_out = s[7];
        s       = {s[6:0], fb};
      end
      if (high_first) begin
        acc = {acc[6:0], bit_out};
      end else begin
        acc[i[2:0]] = bit_out;
      end
    end
    res.key        = acc;
    res.state_next = s;
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lsd_if.sv]
`default_nettype none

interface lsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       end_of_message;

  modport source (output valid, output cipher_byte, output end_of_message, input ready);
  modport sink   (input valid, input cipher_byte, input end_of_message, output ready);
endinterface

interface lsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       char_allowed;
  logic       last_out;

  modport source (output valid, output plain_byte, output char_allowed, output last_out,
                  input ready);
  modport sink   (input valid, input plain_byte, input char_allowed, input last_out,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/lfsr_stream_decryptor.sv]
// lfsr_stream_decryptor
// Decrypts a byte stream with an 8-bit Fibonacci LFSR keystream.
// Channels: cipher_ch (sink) takes one request per cipher byte with an
// end_of_message flag; plain_ch (source) returns one request per byte with
// the plain byte (or '?' when not in the allowed mask), char_allowed and
// last_out. Handshake is valid/ready on both sides.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle; write
// only while no request is in flight.
// Output: each result is registered in the output stage before plain_ch.valid.
// Throughput: one byte per cycle while the skid register is empty; the eight
// LFSR shifts per byte are unrolled XOR logic in front of the output register.
// Stall: a two-entry output stage (output register plus skid register)
// keeps cipher_ch.ready high while the output stalls and the skid is empty;
// ready drops only when both entries hold results.
// Reset (rst, synchronous): registers return to defaults, LFSR loads seed 1,
// output stage empties. The LFSR reloads initial_state after each byte
// flagged end_of_message.
`default_nettype none

module lfsr_stream_decryptor (
  input  wire logic        clk,
  input  wire logic        rst,
  lsd_in_if.sink           cipher_ch,
  lsd_out_if.source        plain_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [7:0]   tap_mask;
  logic [7:0]   initial_state;
  logic         right_shift_mode;
  logic         high_first_mode;
  logic [63:0]  allowed_0;
  logic [63:0]  allowed_1;
  logic [63:0]  allowed_2;
  logic [63:0]  allowed_3;
  logic [7:0]   lfsr;

  logic         out_valid;
  lsd_pkg::result_t out_data;
  logic         skid_valid;
  lsd_pkg::result_t skid_data;

  logic         accept;
  lsd_pkg::keystream_t ks;
  logic [7:0]   plain;
  logic [255:0] allowed_all;
  logic         ok;
  lsd_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_mask         <= lsd_pkg::RST_TAP_MASK;
      initial_state    <= lsd_pkg::RST_INITIAL_STATE;
      right_shift_mode <= 1'b0;
      high_first_mode  <= 1'b0;
      allowed_0        <= lsd_pkg::RST_ALLOWED_0;
      allowed_1        <= lsd_pkg::RST_ALLOWED_1;
      allowed_2        <= lsd_pkg::RST_ALLOWED_2;
      allowed_3        <= lsd_pkg::RST_ALLOWED_3;
    end else if (cfg_we) begin
      case (cfg_index)
        lsd_pkg::REG_TAP_MASK:      tap_mask         <= cfg_data[7:0];
        lsd_pkg::REG_INITIAL_STATE: initial_state    <= cfg_data[7:0];
        lsd_pkg::REG_RIGHT_SHIFT:   right_shift_mode <= cfg_data[0];
        lsd_pkg::REG_HIGH_FIRST:    high_first_mode  <= cfg_data[0];
        lsd_pkg::REG_ALLOWED_0:     allowed_0        <= cfg_data;
        lsd_pkg::REG_ALLOWED_1:     allowed_1        <= cfg_data;
        lsd_pkg::REG_ALLOWED_2:     allowed_2        <= cfg_data;
        lsd_pkg::REG_ALLOWED_3:     allowed_3        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept      = cipher_ch.valid && cipher_ch.ready;
  assign ks          = lsd_pkg::keystream(lfsr, tap_mask, right_shift_mode, high_first_mode);
  assign plain       = cipher_ch.cipher_byte ^ ks.key;
  assign allowed_all = {allowed_3, allowed_2, allowed_1, allowed_0};
  assign ok          = allowed_all[plain];

  always_comb begin
    res.plain_byte   = ok ? plain : lsd_pkg::QUESTION_MARK;
    res.char_allowed = ok;
    res.last_out     = cipher_ch.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= lsd_pkg::RST_INITIAL_STATE;
    end else if (accept) begin
      lfsr <= cipher_ch.end_of_message ? initial_state : ks.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !plain_ch.ready) begin
      if (accept) begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
      if (accept) begin
        out_data <= res;
      end
    end
  end

  assign cipher_ch.ready       = !skid_valid;
  assign plain_ch.valid        = out_valid;
  assign plain_ch.plain_byte   = out_data.plain_byte;
  assign plain_ch.char_allowed = out_data.char_allowed;
  assign plain_ch.last_out     = out_data.last_out;

endmodule

`default_nettype wire

[hw/rtl/lsd_checker.sv]
`default_nettype none

module lsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] plain_byte,
  input wire logic       char_allowed,
  input wire logic       last_out
);

  // input side is open right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> in_ready)
    else $error("in ready low after reset");

  // a request taken while the output stalls fills the skid entry
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready && in_valid && in_ready) |=> !in_ready)
    else $error("skid entry not full after stalled accept");

  // rejected bytes come out as '?'
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !char_allowed) |-> (plain_byte == lsd_pkg::QUESTION_MARK))
    else $error("rejected byte not replaced");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=>
      ($stable(plain_byte) && $stable(char_allowed) && $stable(last_out)))
    else $error("output payload changed while stalled");

endmodule

bind lfsr_stream_decryptor lsd_checker u_lsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cipher_ch.valid),
  .in_ready     (cipher_ch.ready),
  .out_valid    (plain_ch.valid),
  .out_ready    (plain_ch.ready),
  .plain_byte   (plain_ch.plain_byte),
  .char_allowed (plain_ch.char_allowed),
  .last_out     (plain_ch.last_out)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 140;

  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_SPACE = " ";

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  lsd_in_if  cipher_ch ();
  lsd_out_if plain_ch ();

  lfsr_stream_decryptor uut (
    .clk       (clk),
    .rst       (rst),
    .cipher_ch (cipher_ch),
    .plain_ch  (plain_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block's registers and keystream state
  logic [7:0]  taps_m;
  logic [7:0]  seed_m;
  logic        right_shift_m;
  logic        high_first_m;
  logic [63:0] allow_m [4];
  logic [7:0]  lfsr_m;

  lsd_pkg::result_t plain_q [$];
  int          errors = 0;
  int          hold_cycles = 0;
  rx_mode_t    ready_mode = RX_ALWAYS;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_idx = 4'd0;
  bit          gaps_on = 1'b0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] run_lfsr(inout logic [7:0] st);
    logic [7:0] key;
    logic       fb;
    logic       b;
    int         i;
    key = 8'd0;
    for (i = 0; i < 8; i++) begin
      fb = ^(st & taps_m);
      if (right_shift_m) begin
        b  = st[0];
        st = {fb, st[7:1]};
      end else begin
        b  = st[7];
        st = {st[6:0], fb};
      end
      if (high_first_m) begin
        key = {key[6:0], b};
      end else begin
        key[i[2:0]] = b;
      end
    end
    return key;
  endfunction

  function automatic logic [7:0] peek_key();
    logic [7:0] st;
    st = lfsr_m;
    return run_lfsr(st);
  endfunction

  function automatic lsd_pkg::result_t decrypt_next(input logic [7:0] c, input logic eom);
    lsd_pkg::result_t r;
    logic [7:0] st;
    logic [7:0] key;
    logic [7:0] p;
    logic       ok;
    st  = lfsr_m;
    key = run_lfsr(st);
    p   = c ^ key;
    ok  = allow_m[p[7:6]][p[5:0]];
    r.plain_byte   = ok ? p : lsd_pkg::QUESTION_MARK;
    r.char_allowed = ok;
    r.last_out     = eom;
    lfsr_m = eom ? seed_m : st;
    return r;
  endfunction

  task automatic reset_shadow();
    taps_m        = lsd_pkg::RST_TAP_MASK;
    seed_m        = lsd_pkg::RST_INITIAL_STATE;
    right_shift_m = 1'b0;
    high_first_m  = 1'b0;
    allow_m[0]    = lsd_pkg::RST_ALLOWED_0;
    allow_m[1]    = lsd_pkg::RST_ALLOWED_1;
    allow_m[2]    = lsd_pkg::RST_ALLOWED_2;
    allow_m[3]    = lsd_pkg::RST_ALLOWED_3;
    lfsr_m        = lsd_pkg::RST_INITIAL_STATE;
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eom);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        cipher_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    cipher_ch.valid          <= 1'b1;
    cipher_ch.cipher_byte    <= c;
    cipher_ch.end_of_message <= eom;
    do @(posedge clk); while (!cipher_ch.ready);
    plain_q.push_back(decrypt_next(c, eom));
  endtask

  task automatic wait_results();
    @(negedge clk);
    cipher_ch.valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lsd_pkg::REG_TAP_MASK:      taps_m        = val[7:0];
      lsd_pkg::REG_INITIAL_STATE: seed_m        = val[7:0];
      lsd_pkg::REG_RIGHT_SHIFT:   right_shift_m = val[0];
      lsd_pkg::REG_HIGH_FIRST:    high_first_m  = val[0];
      lsd_pkg::REG_ALLOWED_0:     allow_m[0]    = val;
      lsd_pkg::REG_ALLOWED_1:     allow_m[1]    = val;
      lsd_pkg::REG_ALLOWED_2:     allow_m[2]    = val;
      lsd_pkg::REG_ALLOWED_3:     allow_m[3]    = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_values();
    send_byte(peek_key() ^ CH_A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_results();
  endtask

  task automatic test_allowed_zero();
    write_reg(lsd_pkg::REG_ALLOWED_0, 64'h1);
    send_byte(peek_key(), 1'b0);
    send_byte(peek_key() ^ CH_SPACE, 1'b0);
    wait_results();
  endtask

  task automatic test_seed_reload();
    // upper bits of the write data must be dropped
    write_reg(lsd_pkg::REG_INITIAL_STATE, 64'hFFFF_FFFF_FFFF_FF80);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    wait_results();
  endtask

  task automatic test_zero_seed();
    write_reg(lsd_pkg::REG_INITIAL_STATE, 64'h0);
    send_byte(8'h3C, 1'b1);
    send_byte(CH_A, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_results();
  endtask

  task automatic test_zero_taps();
    write_reg(lsd_pkg::REG_TAP_MASK, 64'h0);
    write_reg(lsd_pkg::REG_INITIAL_STATE, 64'hA5);
    send_byte(8'h00, 1'b1);
    send_byte(peek_key() ^ CH_Z, 1'b0);
    send_byte(8'h81, 1'b0);
    wait_results();
  endtask

  task automatic test_shift_modes();
    int m;
    write_reg(lsd_pkg::REG_TAP_MASK, 64'hB8);
    write_reg(lsd_pkg::REG_INITIAL_STATE, 64'hFF);
    write_reg(lsd_pkg::REG_ALLOWED_0, '1);
    write_reg(lsd_pkg::REG_ALLOWED_1, '1);
    write_reg(lsd_pkg::REG_ALLOWED_2, '1);
    write_reg(lsd_pkg::REG_ALLOWED_3, '1);
    for (m = 0; m < 4; m++) begin
      write_reg(lsd_pkg::REG_RIGHT_SHIFT, 64'(m[0]));
      write_reg(lsd_pkg::REG_HIGH_FIRST, 64'(m[1]));
      send_byte(peek_key() ^ lsd_pkg::QUESTION_MARK, 1'b1);
      send_byte(8'(m * 8'h55), 1'b0);
      wait_results();
    end
  endtask

  task automatic test_backpressure();
    int k;
    ready_mode = RX_ALWAYS;
    gaps_on    = 1'b0;
    hold_cycles = 80;
    for (k = 0; k < 24; k++) begin
      send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
    wait_results();
  endtask

  task automatic test_random_traffic();
    int         ph;
    int         k;
    int         len;
    int         sent;
    bit         noisy;
    logic [7:0] c;
    logic       eom;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(lsd_pkg::REG_TAP_MASK, 64'hFF);
          write_reg(lsd_pkg::REG_INITIAL_STATE, 64'hFF);
          write_reg(lsd_pkg::REG_ALLOWED_0, '1);
          write_reg(lsd_pkg::REG_ALLOWED_1, '1);
          write_reg(lsd_pkg::REG_ALLOWED_2, '1);
          write_reg(lsd_pkg::REG_ALLOWED_3, '1);
        end
        1: begin
          write_reg(lsd_pkg::REG_TAP_MASK, 64'h0);
          write_reg(lsd_pkg::REG_INITIAL_STATE, 64'h1);
          write_reg(lsd_pkg::REG_ALLOWED_0, '0);
          write_reg(lsd_pkg::REG_ALLOWED_1, '0);
          write_reg(lsd_pkg::REG_ALLOWED_2, '0);
          write_reg(lsd_pkg::REG_ALLOWED_3, '0);
        end
        default: begin
          write_reg(lsd_pkg::REG_TAP_MASK, 64'($urandom));
          write_reg(lsd_pkg::REG_INITIAL_STATE,
                    ($urandom_range(0, 9) == 0) ? 64'h0 : 64'($urandom_range(1, 255)));
          write_reg(lsd_pkg::REG_ALLOWED_0, {$urandom, $urandom});
          write_reg(lsd_pkg::REG_ALLOWED_1, {$urandom, $urandom});
          write_reg(lsd_pkg::REG_ALLOWED_2, {$urandom, $urandom} & {$urandom, $urandom});
          write_reg(lsd_pkg::REG_ALLOWED_3, {$urandom, $urandom} | {$urandom, $urandom});
        end
      endcase
      write_reg(lsd_pkg::REG_RIGHT_SHIFT,
                (ph < 4) ? 64'(ph % 2) : 64'($urandom_range(0, 1)));
      write_reg(lsd_pkg::REG_HIGH_FIRST,
                (ph < 4) ? 64'(ph / 2) : 64'($urandom_range(0, 1)));

      if (ph == 0) begin
        ready_mode = RX_ALWAYS;
        gaps_on    = 1'b0;
      end else begin
        ready_mode = rx_mode_t'($urandom_range(0, 2));
        stall_pat  = 16'($urandom) | 16'h1;
        gaps_on    = 1'($urandom_range(0, 1));
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len   = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(1, 20);
        noisy = ($urandom_range(0, 9) == 0);
        if (ph != 0 && $urandom_range(0, 19) == 0) hold_cycles = $urandom_range(10, 50);
        for (k = 0; k < len; k++) begin
          c   = ($urandom_range(0, 2) == 0) ? (peek_key() ^ 8'($urandom_range(CH_A, CH_Z)))
                                            : 8'($urandom);
          eom = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
          send_byte(c, eom);
        end
        sent += len;
      end
      wait_results();
    end
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      plain_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      case (ready_mode)
        RX_RANDOM: plain_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: begin
          plain_ch.ready <= stall_pat[pat_idx];
          pat_idx++;
        end
        default: plain_ch.ready <= 1'b1;
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    lsd_pkg::result_t exp_r;
    if (!rst && plain_ch.valid && plain_ch.ready) begin
      if (plain_q.size() == 0) begin
        $error("unexpected result: plain_byte %0h", plain_ch.plain_byte);
        errors++;
      end else begin
        exp_r = plain_q.pop_front();
        if (plain_ch.plain_byte !== exp_r.plain_byte) begin
          $error("plain_byte: expected %0h, got %0h", exp_r.plain_byte, plain_ch.plain_byte);
          errors++;
        end
        if (plain_ch.char_allowed !== exp_r.char_allowed) begin
          $error("char_allowed: expected %0b, got %0b", exp_r.char_allowed,
                 plain_ch.char_allowed);
          errors++;
        end
        if (plain_ch.last_out !== exp_r.last_out) begin
          $error("last_out: expected %0b, got %0b", exp_r.last_out, plain_ch.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_we || (cipher_ch.valid && cipher_ch.ready) ||
        (plain_ch.valid && plain_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = lsd_pkg::REG_TAP_MASK;
    cfg_data                 = 64'h0;
    cipher_ch.valid          = 1'b0;
    cipher_ch.cipher_byte    = 8'h00;
    cipher_ch.end_of_message = 1'b0;
    reset_shadow();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_allowed_zero();
    test_seed_reload();
    test_zero_seed();
    test_zero_taps();
    test_shift_modes();
    test_backpressure();
    test_random_traffic();

    wait_results();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lsd_pkg.sv
hw/rtl/lsd_if.sv
hw/rtl/lfsr_stream_decryptor.sv
hw/rtl/lsd_checker.sv
dv/tb_top.sv
